// ----- rtl/mcpwm_pkg.sv -----
package mcpwm_pkg;

    localparam int CHANNELS = 4;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 8;
    localparam int CTRL_W   = 3;

    // Bit positions inside the global register and a channel control register.
    localparam int GLB_DONE_LSB = 4;
    localparam int CTRL_EN_BIT  = 0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // Word offset inside a channel block, taken from address bits [3:2].
    typedef enum logic [1:0] {
        OFF_CTRL   = 2'd0,
        OFF_PERIOD = 2'd1,
        OFF_DUTY   = 2'd2,
        OFF_COUNT  = 2'd3
    } reg_off_t;

    localparam logic [ADDR_W-1:0] GLOBAL_ADDR = 8'h00;
    localparam logic [3:0]        CH_BLK_BASE = 4'h1;

    typedef struct packed {
        logic              tick;
        logic              ctrl_we;
        logic              period_we;
        logic              duty_we;
        logic [DATA_W-1:0] wdata;
    } ch_ctl_t;

    typedef struct packed {
        logic [CTRL_W-1:0] control;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] duty;
        logic [DATA_W-1:0] count_view;
        logic              wrap;
    } ch_stat_t;

endpackage

// ----- rtl/mcpwm_req_if.sv -----
interface mcpwm_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [mcpwm_pkg::ADDR_W-1:0]   address;
    logic [mcpwm_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output command, output address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    output ready);
endinterface

// ----- rtl/mcpwm_rsp_if.sv -----
interface mcpwm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mcpwm_pkg::DATA_W-1:0]   read_data;
    logic                           irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink   (input valid, input read_data, input irq, output ready);
endinterface

// ----- rtl/mcpwm_channel.sv -----
module mcpwm_channel (
    input  logic                clk,
    input  logic                rst_n,
    input  mcpwm_pkg::ch_ctl_t  ctl,
    output mcpwm_pkg::ch_stat_t stat
);

    logic [mcpwm_pkg::CTRL_W-1:0] control_reg, control_next;
    logic [mcpwm_pkg::DATA_W-1:0] period_reg, period_next;
    logic [mcpwm_pkg::DATA_W-1:0] duty_reg, duty_next;
    logic [mcpwm_pkg::DATA_W-1:0] count_reg, count_next;
    logic                         running;
    logic                         at_end;

    assign running = control_reg[mcpwm_pkg::CTRL_EN_BIT] && (period_reg != '0);
    assign at_end  = count_reg >= period_reg;

    always_comb
    begin
        control_next = control_reg;
        period_next  = period_reg;
        duty_next    = duty_reg;
        count_next   = count_reg;
        if (ctl.ctrl_we)
        begin
            control_next = ctl.wdata[mcpwm_pkg::CTRL_W-1:0];
            // A rising edge of enable restarts the counter.
            if (!control_reg[mcpwm_pkg::CTRL_EN_BIT] && ctl.wdata[mcpwm_pkg::CTRL_EN_BIT])
            begin
                count_next = '0;
            end
        end
        if (ctl.period_we)
        begin
            period_next = ctl.wdata;
        end
        if (ctl.duty_we)
        begin
            duty_next = ctl.wdata;
        end
        if (ctl.tick && running)
        begin
            if (at_end)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            period_reg  <= '0;
            duty_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            control_reg <= control_next;
            period_reg  <= period_next;
            duty_reg    <= duty_next;
            count_reg   <= count_next;
        end
    end

    assign stat.control    = control_reg;
    assign stat.period     = period_reg;
    assign stat.duty       = duty_reg;
    assign stat.count_view = running ? count_reg : '0;
    assign stat.wrap       = ctl.tick && running && at_end;

endmodule

// ----- rtl/multi_channel_pwm_period_timer.sv -----
// Channel | Direction | Fields
// req     | in        | command[1:0], address[7:0], write_data[31:0]
// rsp     | out       | read_data[31:0], irq
//
// Every request transaction yields exactly one response transaction, via the request
// register and then the response register. One transaction is taken per cycle while the
// response side is not stalled; each channel's counter advance and period compare sit
// between them. A stalled response holds the request register, which in turn drops
// req.ready. Reset is asynchronous and clears all channel registers and done flags.
module multi_channel_pwm_period_timer (
    input  logic        clk,
    input  logic        rst_n,
    mcpwm_req_if.sink   req,
    mcpwm_rsp_if.source rsp
);

    logic                          in_vld_reg;
    logic [1:0]                    cmd_reg;
    logic [mcpwm_pkg::ADDR_W-1:0]  addr_reg;
    logic [mcpwm_pkg::DATA_W-1:0]  data_reg;

    logic                          out_vld_reg;
    logic [mcpwm_pkg::DATA_W-1:0]  rd_reg, rd_next;
    logic                          irq_reg;

    logic [mcpwm_pkg::CHANNELS-1:0] done_reg, done_next;
    logic [mcpwm_pkg::CHANNELS-1:0] wrap_set;
    logic [mcpwm_pkg::CHANNELS-1:0] ch_hit;

    mcpwm_pkg::ch_ctl_t  ch_ctl  [mcpwm_pkg::CHANNELS];
    mcpwm_pkg::ch_stat_t ch_stat [mcpwm_pkg::CHANNELS];

    logic advance;
    logic is_tick;
    logic is_read;
    logic is_write;
    logic glb_hit;
    mcpwm_pkg::reg_off_t off;

    assign advance  = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;

    assign is_tick  = advance && (cmd_reg == mcpwm_pkg::CMD_TICK);
    assign is_read  = cmd_reg == mcpwm_pkg::CMD_READ;
    assign is_write = advance && (cmd_reg == mcpwm_pkg::CMD_WRITE);
    assign glb_hit  = addr_reg == mcpwm_pkg::GLOBAL_ADDR;
    assign off      = mcpwm_pkg::reg_off_t'(addr_reg[3:2]);

    for (genvar n = 0; n < mcpwm_pkg::CHANNELS; n++)
    begin : g_ch
        assign ch_hit[n] = (addr_reg[7:4] == mcpwm_pkg::CH_BLK_BASE + 4'(n))
                           && (addr_reg[1:0] == 2'b00);

        assign ch_ctl[n].tick      = is_tick;
        assign ch_ctl[n].ctrl_we   = is_write && ch_hit[n] && (off == mcpwm_pkg::OFF_CTRL);
        assign ch_ctl[n].period_we = is_write && ch_hit[n] && (off == mcpwm_pkg::OFF_PERIOD);
        assign ch_ctl[n].duty_we   = is_write && ch_hit[n] && (off == mcpwm_pkg::OFF_DUTY);
        assign ch_ctl[n].wdata     = data_reg;

        mcpwm_channel u_channel (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ch_ctl[n]),
            .stat (ch_stat[n])
        );

        assign wrap_set[n] = ch_stat[n].wrap;
    end

    always_comb
    begin
        done_next = done_reg | wrap_set;
        if (is_write && glb_hit)
        begin
            done_next = done_reg
                & ~data_reg[mcpwm_pkg::GLB_DONE_LSB +: mcpwm_pkg::CHANNELS];
        end
    end

    always_comb
    begin
        rd_next = '0;
        if (is_read)
        begin
            for (int n = 0; n < mcpwm_pkg::CHANNELS; n++)
            begin
                if (glb_hit)
                begin
                    rd_next[n] = ch_stat[n].control[mcpwm_pkg::CTRL_EN_BIT];
                    rd_next[mcpwm_pkg::GLB_DONE_LSB + n] = done_reg[n];
                end
                else if (ch_hit[n])
                begin
                    case (off)
                        mcpwm_pkg::OFF_CTRL:
                            rd_next = mcpwm_pkg::DATA_W'(ch_stat[n].control);
                        mcpwm_pkg::OFF_PERIOD:
                            rd_next = ch_stat[n].period;
                        mcpwm_pkg::OFF_DUTY:
                            rd_next = ch_stat[n].duty;
                        mcpwm_pkg::OFF_COUNT:
                            rd_next = ch_stat[n].count_view;
                        default:
                            rd_next = '0;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            cmd_reg     <= '0;
            addr_reg    <= '0;
            data_reg    <= '0;
            out_vld_reg <= 1'b0;
            rd_reg      <= '0;
            irq_reg     <= 1'b0;
            done_reg    <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_vld_reg <= req.valid;
                if (req.valid)
                begin
                    cmd_reg  <= req.command;
                    addr_reg <= req.address;
                    data_reg <= req.write_data;
                end
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                rd_reg      <= rd_next;
                irq_reg     <= |done_next;
                done_reg    <= done_next;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.read_data = rd_reg;
    assign rsp.irq       = irq_reg;

endmodule
